// ===== hw/rtl/fcsv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsv_pkg: shared types and constants of the FIR convolution block
// Word formats, register map, job descriptor and fixed-point widths.
// ----------------------------------------------------------------------------
package fcsv_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 16;
	localparam int COEF_FRAC_BITS = 14;
	// Fifteen programmable coefficients plus one slot that always reads zero.
	localparam int COEF_SLOTS     = 16;
	localparam int MASK_BITS      = 4;
	localparam int MASK_CAP       = 15;
	localparam int CNT_BITS       = 4;
	localparam int DEF_MAX_TAPS   = 15;
	localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
	localparam int GRP_SIZE       = 4;
	localparam int GRP_BITS       = PROD_BITS + $clog2(GRP_SIZE);

	localparam int APB_DATA_BITS  = 64;
	localparam int APB_ADDR_BITS  = 6;
	localparam int REG_IDX_LSB    = 3;
	localparam int REG_IDX_BITS   = APB_ADDR_BITS - REG_IDX_LSB;
	localparam int COEF_D_BITS    = 48;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;

	localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_MASK_SIZE = 3'd0,
		REG_MODE      = 3'd1,
		REG_COEF_A    = 3'd2,
		REG_COEF_B    = 3'd3,
		REG_COEF_C    = 3'd4,
		REG_COEF_D    = 3'd5
	} reg_idx_t;

	typedef enum logic {
		MODE_SAME  = 1'b0,
		MODE_VALID = 1'b1
	} mode_t;

	typedef struct packed {
		sample_t sample;
		logic    end_of_signal;
	} smp_word_t;

	typedef struct packed {
		sample_t value;
		logic    final_res;
		logic    clipped;
	} res_word_t;

	// What one sample turns into: whether the first word is a computed value,
	// how many words in total, and whether the signal ends here.
	typedef struct packed {
		logic                full;
		logic [CNT_BITS-1:0] cnt;
		logic                last;
	} job_t;

	typedef struct packed {
		job_t    job;
		sample_t value;
		logic    clipped;
	} mac_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fcsv_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsv_mac: three-stage multiply, add tree and saturation
// Stage one multiplies every tap by its coefficient, stage two forms sums of
// up to four products, stage three adds the groups, scales and saturates.
// ----------------------------------------------------------------------------
module fcsv_mac
	import fcsv_pkg::*;
#(
	parameter int NLANE = DEF_MAX_TAPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  job_t                 job,
	input  sample_t              taps [NLANE],
	input  coef_t                coefs [COEF_SLOTS],
	input  logic [MASK_BITS-1:0] twoh,
	input  logic                 even_sel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mac_res_t             out_res
);

	localparam int NGRP     = (NLANE + GRP_SIZE - 1) / GRP_SIZE;
	localparam int ACC_BITS = GRP_BITS + $clog2(NGRP) + 1;

	logic rdy_s1, rdy_s2, rdy_s3;
	logic vld_s1, vld_s2, vld_s3;
	job_t job_s1, job_s2;

	prod_t                     prod_c  [NLANE];
	prod_t                     prod_s1 [NLANE];
	logic signed [GRP_BITS-1:0] grp_c  [NGRP];
	logic signed [GRP_BITS-1:0] grp_s2 [NGRP];
	logic signed [ACC_BITS-1:0] acc_c, shf_c;
	logic [ACC_BITS-SAMPLE_BITS:0] upper_c;
	mac_res_t res_c, res_s3;

	assign rdy_s3    = !vld_s3 || out_ready;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign job_ready = rdy_s1;
	assign out_valid = vld_s3;
	assign out_res   = res_s3;

	// For an even mask size the window starts one coefficient higher.
	always_comb begin
		for (int k = 0; k < NLANE; k++) begin
			prod_c[k] = taps[k] * (even_sel ? coefs[k+1] : coefs[k]);
			if (MASK_BITS'(k) > twoh) begin
				prod_c[k] = '0;
			end
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_c[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (g * GRP_SIZE + j < NLANE) begin
					grp_c[g] = grp_c[g] + GRP_BITS'(prod_s1[g*GRP_SIZE+j]);
				end
			end
		end
	end

	// The arithmetic shift rounds toward minus infinity.
	always_comb begin
		acc_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			acc_c = acc_c + ACC_BITS'(grp_s2[g]);
		end
		shf_c   = acc_c >>> COEF_FRAC_BITS;
		upper_c = shf_c[ACC_BITS-1:SAMPLE_BITS-1];
		res_c.job = job_s2;
		if ((&upper_c) || !(|upper_c)) begin
			res_c.value   = shf_c[SAMPLE_BITS-1:0];
			res_c.clipped = 1'b0;
		end else begin
			res_c.value   = shf_c[ACC_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
			res_c.clipped = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= job_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			prod_s1 <= prod_c;
			job_s1  <= job;
		end
		if (rdy_s2) begin
			grp_s2 <= grp_c;
			job_s2 <= job_s1;
		end
		if (rdy_s3) begin
			res_s3 <= res_c;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fcsv_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcsv_emit: result word register and burst sequencer
// Holds one job and hands out its words: the computed value first when there
// is one, then the border zeros, with the final flag on the last word of a signal.
// ----------------------------------------------------------------------------
module fcsv_emit
	import fcsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mac_res_t  in_res,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res_data
);

	logic                cur_vld_q;
	logic [CNT_BITS-1:0] rem_q;
	logic                prim_full_q;
	logic                last_q;
	sample_t             val_q;
	logic                clip_q;
	logic                take, load, on_last;

	assign on_last  = (rem_q == CNT_BITS'(1));
	assign take     = res_valid && res_ready;
	assign in_ready = !cur_vld_q || (res_ready && on_last);
	assign load     = in_valid && in_ready;

	assign res_valid          = cur_vld_q;
	assign res_data.value     = prim_full_q ? val_q : '0;
	assign res_data.clipped   = prim_full_q && clip_q;
	assign res_data.final_res = last_q && on_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q   <= 1'b0;
			rem_q       <= '0;
			prim_full_q <= 1'b0;
			last_q      <= 1'b0;
		end else if (load) begin
			cur_vld_q   <= 1'b1;
			rem_q       <= in_res.job.cnt;
			prim_full_q <= in_res.job.full;
			last_q      <= in_res.job.last;
		end else if (take) begin
			rem_q       <= rem_q - CNT_BITS'(1);
			prim_full_q <= 1'b0;
			if (on_last) begin
				cur_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= in_res.value;
			clip_q <= in_res.clipped;
		end
	end

`ifndef SYNTH
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> rem_q != '0)
		else $error("held job has no words left");

	a_full_held: assert property (@(posedge clk) disable iff (!arst_n)
		prim_full_q |-> cur_vld_q)
		else $error("computed value pending without a held job");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		take && (rem_q > CNT_BITS'(1)) |=> res_valid && (rem_q == $past(rem_q) - CNT_BITS'(1)))
		else $error("burst count did not step down by one");

	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_data.final_res && !in_valid |=> !res_valid)
		else $error("word left over after the final result");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fir_convolution_same_valid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result word loads the product, group-sum, saturation and result registers in that order.
// Throughput: one sample word per cycle while each sample yields at most one result word
// and the output takes every word. The final sample of a signal in same mode yields up to
// 1 + h words, one per cycle while the output takes them; while that burst drains, the three
// pipeline stages fill with later words and then the input waits.
// Reset is asynchronous: mask size 3, same mode, zero coefficients, empty window and pipeline.
// ----------------------------------------------------------------------------
// fir_convolution_same_valid: streaming 1-D FIR convolution, same or valid mode
// Centered-window FIR over a delay line of the newest samples, with Q2.14
// coefficients, floor scaling, 16-bit saturation and zero borders in same mode.
// ----------------------------------------------------------------------------
module fir_convolution_same_valid
	import fcsv_pkg::*;
#(
	parameter int MAX_TAPS = DEF_MAX_TAPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     smp_valid,
	output logic                     smp_ready,
	input  smp_word_t                smp_data,
	output logic                     res_valid,
	input  logic                     res_ready,
	output res_word_t                res_data,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	// The mask never spans more than fifteen taps, so the lanes stop there.
	localparam int NLANE     = (MAX_TAPS < MASK_CAP) ? MAX_TAPS : MASK_CAP;
	localparam int WIN_DEPTH = (NLANE > 1) ? NLANE - 1 : 1;

	// Configuration registers.
	logic [MASK_BITS-1:0]     mask_size_q;
	mode_t                    mode_q;
	logic [APB_DATA_BITS-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic [COEF_D_BITS-1:0]   coef_d_q;
	logic                     wr_en;
	reg_idx_t                 reg_idx;

	// Delay line and per-signal sample count.
	sample_t              window_q [WIN_DEPTH];
	logic [MASK_BITS-1:0] seen_q;

	logic [MASK_BITS-1:0] msz_eff, msz_m1, twoh;
	logic [MASK_BITS-1:0] half;
	logic                 even_sel;
	logic                 accept, last;
	logic                 lead_zero, full_win;
	logic [CNT_BITS-1:0]  trail;
	job_t                 job;
	logic                 job_valid, job_ready;
	sample_t              taps [NLANE];
	coef_t                coefs [COEF_SLOTS];
	logic                 mac_valid, mac_ready;
	mac_res_t             mac_res;

	// ------------------------------------------------------------------
	// APB port. Every register sits on an 8-byte boundary, so bits [5:3]
	// of the address pick the register and the low bits are ignored.
	// Writes to unused slots are dropped; reads there return zero.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:REG_IDX_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_size_q <= MASK_BITS'(3);
			mode_q      <= MODE_SAME;
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			coef_c_q    <= '0;
			coef_d_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MASK_SIZE: mask_size_q <= pwdata[MASK_BITS-1:0];
				REG_MODE:      mode_q      <= mode_t'(pwdata[0]);
				REG_COEF_A:    coef_a_q    <= pwdata;
				REG_COEF_B:    coef_b_q    <= pwdata;
				REG_COEF_C:    coef_c_q    <= pwdata;
				REG_COEF_D:    coef_d_q    <= pwdata[COEF_D_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MASK_SIZE: prdata = APB_DATA_BITS'(mask_size_q);
			REG_MODE:      prdata = APB_DATA_BITS'(mode_q);
			REG_COEF_A:    prdata = coef_a_q;
			REG_COEF_B:    prdata = coef_b_q;
			REG_COEF_C:    prdata = coef_c_q;
			REG_COEF_D:    prdata = APB_DATA_BITS'(coef_d_q);
			default:       prdata = '0;
		endcase
	end

	// The coefficient table, sixteen entries with the top one held at zero.
	always_comb begin
		for (int i = 0; i < COEF_SLOTS; i++) begin
			coefs[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			coefs[i]     = coef_a_q[i*COEF_BITS +: COEF_BITS];
			coefs[i + 4] = coef_b_q[i*COEF_BITS +: COEF_BITS];
			coefs[i + 8] = coef_c_q[i*COEF_BITS +: COEF_BITS];
		end
		for (int i = 0; i < 3; i++) begin
			coefs[i + 12] = coef_d_q[i*COEF_BITS +: COEF_BITS];
		end
	end

	// ------------------------------------------------------------------
	// Window geometry. A mask size of zero acts as one, and sizes past
	// the tap count are clamped. Window position k pairs with coefficient
	// k for an odd size and k + 1 for an even size; positions past 2h are
	// masked off in the multiply stage.
	// ------------------------------------------------------------------
	always_comb begin
		if (mask_size_q == '0) begin
			msz_eff = MASK_BITS'(1);
		end else if (mask_size_q > MASK_BITS'(NLANE)) begin
			msz_eff = MASK_BITS'(NLANE);
		end else begin
			msz_eff = mask_size_q;
		end
	end

	assign msz_m1   = msz_eff - MASK_BITS'(1);
	assign twoh     = {msz_m1[MASK_BITS-1:1], 1'b0};
	assign half     = {1'b0, msz_m1[MASK_BITS-1:1]};
	assign even_sel = ~msz_eff[0];

	// ------------------------------------------------------------------
	// Job decision for the incoming sample, based on how many samples of
	// this signal came before it. Same mode gives a leading border zero
	// for each of the first h samples (h = half), a computed value once the
	// window is full, and on the final sample all trailing border zeros
	// still owed. Valid mode gives computed values only. Samples that give
	// no word at all update the delay line and never enter the pipeline.
	// ------------------------------------------------------------------
	assign accept    = smp_valid && smp_ready;
	assign last      = smp_data.end_of_signal;
	assign lead_zero = (seen_q < half);
	assign full_win  = (seen_q >= twoh);

	always_comb begin
		trail = '0;
		if (last) begin
			if (full_win) begin
				trail = CNT_BITS'(half);
			end else if (!lead_zero) begin
				trail = CNT_BITS'(seen_q + MASK_BITS'(1) - half);
			end
		end
		job.last = last;
		job.full = full_win;
		unique case (mode_q)
			MODE_SAME:  job.cnt = CNT_BITS'(lead_zero || full_win) + trail;
			MODE_VALID: job.cnt = CNT_BITS'(full_win);
			default:    job.cnt = '0;
		endcase
	end

	assign job_valid = accept && (job.cnt != '0);
	assign smp_ready = job_ready;

	// The newest sample feeds lane zero straight from the port; the other
	// lanes read the delay line as it stood before this sample.
	always_comb begin
		taps[0] = smp_data.sample;
		for (int k = 1; k < NLANE; k++) begin
			taps[k] = window_q[k-1];
		end
	end

	// The delay line and the sample count are cleared after the final
	// sample, so the next signal starts from an empty window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				window_q[i] <= '0;
			end
		end else if (accept) begin
			if (last) begin
				seen_q <= '0;
				for (int i = 0; i < WIN_DEPTH; i++) begin
					window_q[i] <= '0;
				end
			end else begin
				if (seen_q != '1) begin
					seen_q <= seen_q + MASK_BITS'(1);
				end
				window_q[0] <= smp_data.sample;
				for (int i = 1; i < WIN_DEPTH; i++) begin
					window_q[i] <= window_q[i-1];
				end
			end
		end
	end

	// Multiply, add tree and saturation.
	fcsv_mac #(
		.NLANE(NLANE)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.taps     (taps),
		.coefs    (coefs),
		.twoh     (twoh),
		.even_sel (even_sel),
		.out_valid(mac_valid),
		.out_ready(mac_ready),
		.out_res  (mac_res)
	);

	// Result register; it expands one job into its burst of words.
	fcsv_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mac_valid),
		.in_ready (mac_ready),
		.in_res   (mac_res),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

endmodule
`default_nettype wire
